>>> hw/rtl/lcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_pkg: shared types and constants of the frame receiver
// Word codes, report kinds, register indexes and the structs that pass
// configuration and results between the receiver's modules.
// ----------------------------------------------------------------------------
package lcfr_pkg;

  // Framing constants
  localparam logic [7:0] SOF_BYTE   = 8'h7E;
  localparam logic [7:0] CHECK_BASE = 8'hFF;

  // Configuration register file
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  // Input word operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_OVERFLOW = 3'd2,
    KIND_CSUM_ERR = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0] max_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } res_t;

endpackage

>>> hw/rtl/lcfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_if: valid/ready channels of the frame receiver
// Input word channel, result word channel and configuration write channel.
// ----------------------------------------------------------------------------
interface lcfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface lcfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  output ready);
endinterface

interface lcfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/lcfr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_cfg: configuration registers
// Holds max_length and timeout_ticks, written by index from the cfg channel.
// ----------------------------------------------------------------------------
module lcfr_cfg
  import lcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_MAX_LENGTH:    cfg_nxt.max_length    = wr_data;
        CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length    <= MAX_LENGTH_RST;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/lcfr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfr_step: deframer state and per-word logic
// Hunts for the start byte, takes the big-endian length, passes payload
// bytes, checks the checksum and runs the idle tick counter.
// ----------------------------------------------------------------------------
module lcfr_step
  import lcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step_en,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic [16:0] idle_inc;
  logic [16:0] limit;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic [7:0]  want;

  assign idle_inc = {1'b0, idle_r} + 17'd1;
  // a limit of zero acts as one
  assign limit    = (cfg.timeout_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.timeout_ticks};
  assign len_full = {exp_len_r[15:8], rx_byte};
  assign left_dec = left_r - 16'd1;
  assign want     = CHECK_BASE - sum_r;

  // Next state and result for one word
  always_comb begin
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    left_nxt    = left_r;
    sum_nxt     = sum_r;
    idle_nxt    = idle_r;
    res_valid   = 1'b0;
    res         = '{kind: KIND_DATA, data_byte: 8'd0, frame_length: 16'd0};

    if (operation == OP_TICK) begin
      if (idle_inc >= limit) begin
        idle_nxt  = 16'd0;
        phase_nxt = PH_HUNT;
        left_nxt  = 16'd0;
        sum_nxt   = 8'd0;
        res_valid = 1'b1;
        res.kind  = KIND_TIMEOUT;
      end else begin
        idle_nxt = idle_inc[15:0];
      end
    end else begin
      idle_nxt = 16'd0;
      case (phase_r)
        PH_LEN_HI: begin
          exp_len_nxt = {rx_byte, 8'd0};
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          exp_len_nxt = len_full;
          if (len_full > cfg.max_length) begin
            phase_nxt = PH_HUNT;
            left_nxt  = 16'd0;
            sum_nxt   = 8'd0;
            res_valid = 1'b1;
            res.kind  = KIND_OVERFLOW;
          end else begin
            sum_nxt   = 8'd0;
            left_nxt  = len_full;
            phase_nxt = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt       = sum_r + rx_byte;
          left_nxt      = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_CHECK;
          end
          res_valid     = 1'b1;
          res.kind      = KIND_DATA;
          res.data_byte = rx_byte;
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
          left_nxt  = 16'd0;
          sum_nxt   = 8'd0;
          res_valid = 1'b1;
          if (rx_byte == want) begin
            res.kind         = KIND_GOOD;
            res.frame_length = exp_len_r;
          end else begin
            res.kind = KIND_CSUM_ERR;
          end
        end
        default: begin
          // hunting: only the start byte opens a frame
          phase_nxt = (rx_byte == SOF_BYTE) ? PH_LEN_HI : PH_HUNT;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      exp_len_r <= 16'd0;
      left_r    <= 16'd0;
      sum_r     <= 8'd0;
      idle_r    <= 16'd0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      exp_len_r <= exp_len_nxt;
      left_r    <= left_nxt;
      sum_r     <= sum_nxt;
      idle_r    <= idle_nxt;
    end
  end

endmodule

>>> hw/rtl/length_checksum_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver: start-byte / length / checksum deframer
// Takes one word per cycle (a received byte or a tick) while the sink
// takes the reports; a word is latched in the input register, processed by
// the deframer logic once the output register is free or draining, and its
// report, if any, lands in the output register. in_port.ready drops only
// while the input register is full and the output register holds a report
// that the sink is not taking. Configuration writes are always ready and
// affect words processed after the write.
// ----------------------------------------------------------------------------
module length_checksum_frame_receiver
  import lcfr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  lcfr_in_if.sink    in_port,
  lcfr_out_if.source out_port,
  lcfr_cfg_if.sink   cfg_port
);

  cfg_t cfg;
  logic in_v_r, in_v_nxt;
  logic in_op_r;
  logic [7:0] in_byte_r;
  logic step_en;
  logic res_valid;
  res_t res;
  logic out_v_r, out_v_nxt;
  res_t out_r;

  // Configuration registers
  assign cfg_port.ready = 1'b1;

  lcfr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_port.valid),
    .wr_index (cfg_port.index),
    .wr_data  (cfg_port.wdata),
    .cfg      (cfg)
  );

  // Input register: advances when the output slot is free or draining
  assign step_en       = in_v_r && (!out_v_r || out_port.ready);
  assign in_port.ready = !in_v_r || step_en;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_port.valid && in_port.ready) begin
      in_v_nxt = 1'b1;
    end else if (step_en) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_port.valid && in_port.ready) begin
      in_op_r   <= in_port.operation;
      in_byte_r <= in_port.rx_byte;
    end
  end

  // Deframer step
  lcfr_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .operation (in_op_r),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (step_en && res_valid) begin
      out_v_nxt = 1'b1;
    end else if (out_port.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_r <= res;
    end
  end

  assign out_port.valid        = out_v_r;
  assign out_port.kind         = out_r.kind;
  assign out_port.data_byte    = out_r.data_byte;
  assign out_port.frame_length = out_r.frame_length;

endmodule
